// ----- hdl/rvex_pkg.sv -----
// Package for the RV32IM execute unit: constants, payload and pipeline types,
// and the base ALU function. No dependencies.
`default_nettype none
package rvex_pkg;

    localparam int XLEN = 32;

    localparam logic [6:0] OPC_LOAD   = 7'h03;
    localparam logic [6:0] OPC_OPIMM  = 7'h13;
    localparam logic [6:0] OPC_AUIPC  = 7'h17;
    localparam logic [6:0] OPC_STORE  = 7'h23;
    localparam logic [6:0] OPC_OP     = 7'h33;
    localparam logic [6:0] OPC_LUI    = 7'h37;
    localparam logic [6:0] OPC_BRANCH = 7'h63;
    localparam logic [6:0] OPC_JALR   = 7'h67;
    localparam logic [6:0] OPC_JAL    = 7'h6F;

    localparam logic [6:0] F7_BASE   = 7'h00;
    localparam logic [6:0] F7_MULDIV = 7'h01;
    localparam logic [6:0] F7_ALT    = 7'h20;

    localparam logic [1:0] MEM_NONE  = 2'd0;
    localparam logic [1:0] MEM_LOAD  = 2'd1;
    localparam logic [1:0] MEM_STORE = 2'd2;

    localparam logic [1:0] SIZE_BYTE = 2'd0;
    localparam logic [1:0] SIZE_HALF = 2'd1;
    localparam logic [1:0] SIZE_WORD = 2'd2;

    typedef enum logic [2:0] {
        SEL_ALU,
        SEL_MUL_LO,
        SEL_MUL_HI,
        SEL_DIV_Q,
        SEL_DIV_R
    } t_res_sel;

    typedef struct packed {
        logic [6:0]         major_opcode;
        logic [2:0]         minor_func;
        logic [6:0]         variant_func;
        logic signed [31:0] src1_value;
        logic signed [31:0] src2_value;
        logic signed [31:0] immediate;
        logic [31:0]        instr_addr;
        logic [31:0]        load_raw;
    } t_exe_in;

    typedef struct packed {
        logic signed [31:0] write_value;
        logic               write_enable;
        logic [31:0]        next_addr;
        logic               branch_taken;
        logic [31:0]        mem_addr;
        logic [31:0]        st_data;
        logic [1:0]         mem_access;
        logic [1:0]         access_size;
        logic               unknown_op;
    } t_exe_out;

    // Result fields plus what the final stage needs to finish a multiply or divide.
    typedef struct packed {
        t_exe_out res;
        t_res_sel sel;
        logic     neg_q;
        logic     neg_r;
        logic     div_zero;
    } t_side;

    function automatic logic [31:0] alu_base(input logic [2:0] f3, input logic alt,
                                             input logic [31:0] a, input logic [31:0] b);
        logic [4:0]  sh;
        logic [31:0] r;
        sh = b[4:0];
        case (f3)
            3'd0:    r = alt ? a - b : a + b;
            3'd1:    r = a << sh;
            3'd2:    r = {31'd0, $signed(a) < $signed(b)};
            3'd3:    r = {31'd0, a < b};
            3'd4:    r = a ^ b;
            3'd5:    r = alt ? 32'($signed(a) >>> sh) : a >> sh;
            3'd6:    r = a | b;
            default: r = a & b;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- hdl/rvex_div.sv -----
// Pipelined restoring divider on unsigned magnitudes, one quotient bit per stage.
// Depends on rvex_pkg for the word width.
`default_nettype none
module rvex_div (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic [rvex_pkg::XLEN-1:0] i_dividend,
    input  logic [rvex_pkg::XLEN-1:0] i_divisor,
    output logic [rvex_pkg::XLEN-1:0] o_quot,
    output logic [rvex_pkg::XLEN-1:0] o_rem
);
    localparam int W = rvex_pkg::XLEN;

    logic [W-1:0] r_rem [W];
    logic [W-1:0] r_quo [W];
    logic [W-1:0] r_dvs [W];

    for (genvar s = 0; s < W; s++) begin : g_stage
        logic [W-1:0] rem_in, quo_in, dvs_in, n_rem, n_quo;
        logic [W:0]   trial, diff;
        if (s == 0) begin : g_first
            assign rem_in = '0;
            assign quo_in = i_dividend;
            assign dvs_in = i_divisor;
        end else begin : g_next
            assign rem_in = r_rem[s-1];
            assign quo_in = r_quo[s-1];
            assign dvs_in = r_dvs[s-1];
        end
        always_comb begin
            trial = {rem_in, quo_in[W-1]};
            diff  = trial - {1'b0, dvs_in};
            n_rem = diff[W] ? trial[W-1:0] : diff[W-1:0];
            n_quo = {quo_in[W-2:0], ~diff[W]};
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s] <= n_rem;
                r_quo[s] <= n_quo;
                r_dvs[s] <= dvs_in;
            end
        end
    end

    assign o_quot = r_quo[W-1];
    assign o_rem  = r_rem[W-1];
endmodule
`default_nettype wire

// ----- hdl/rv32im_execute_unit.sv -----
// RV32IM execute unit top level: decode of operation groups, ALU, multiplier
// and result assembly around the pipelined divider. Depends on rvex_pkg, rvex_div.
//
// Usage: one decoded instruction enters per transaction on the input channel
// (i_in_valid/o_in_ready, payload i_in_data) and exactly one result leaves per
// transaction on the output channel (o_out_valid/i_out_ready, payload
// o_out_data), in order. Every instruction takes the same path: the input
// register captures at acceptance, then a stage for the ALU, decode and the
// 33x33 multiplier, XLEN stages of the divider (one quotient bit each) and
// the output register. Throughput is one instruction per cycle while the
// receiver takes results. When the receiver stalls with a result waiting,
// the whole pipeline holds; empty stages do not advance separately, and
// o_in_ready falls only while the output register is full and not being
// taken. A synchronous active-low reset clears all valid bits; the pipeline
// is empty and ready in the first cycle after reset.
`default_nettype none
module rv32im_execute_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  rvex_pkg::t_exe_in i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output rvex_pkg::t_exe_out o_out_data
);
    localparam int W = rvex_pkg::XLEN;

    logic en;
    assign en = !o_out_valid || i_out_ready;
    assign o_in_ready = en;

    // Input register.
    logic              r_in_vld;
    rvex_pkg::t_exe_in r_in;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (en) begin
            r_in_vld <= i_in_valid;
        end
        if (en) begin
            r_in <= i_in_data;
        end
    end

    // Decode and combinational work.
    logic [31:0] a, b, imm, pc, raw;
    logic [2:0]  f3;
    logic [6:0]  f7;
    rvex_pkg::t_side n_s1;
    logic        sa, sb, div_signed, na, nb;
    logic [31:0] n_dividend, n_divisor;
    logic        cond;

    always_comb begin
        a   = r_in.src1_value;
        b   = r_in.src2_value;
        imm = r_in.immediate;
        pc  = r_in.instr_addr;
        raw = r_in.load_raw;
        f3  = r_in.minor_func;
        f7  = r_in.variant_func;
        cond = 1'b0;

        n_s1 = '0;
        n_s1.sel = rvex_pkg::SEL_ALU;
        n_s1.res.next_addr = pc + 32'd4;

        div_signed = !f3[0];
        na = div_signed && a[31];
        nb = div_signed && b[31];
        n_dividend = na ? 32'd0 - a : a;
        n_divisor  = nb ? 32'd0 - b : b;
        n_s1.neg_q = na ^ nb;
        n_s1.neg_r = na;
        n_s1.div_zero = (b == 32'd0);
        sa = (f3 == 3'd1) || (f3 == 3'd2);
        sb = (f3 == 3'd1);

        unique case (r_in.major_opcode)
            rvex_pkg::OPC_OP: begin
                if (f7 == rvex_pkg::F7_BASE) begin
                    n_s1.res.write_value  = rvex_pkg::alu_base(f3, 1'b0, a, b);
                    n_s1.res.write_enable = 1'b1;
                end else if (f7 == rvex_pkg::F7_MULDIV) begin
                    n_s1.res.write_enable = 1'b1;
                    case (f3)
                        3'd0:               n_s1.sel = rvex_pkg::SEL_MUL_LO;
                        3'd1, 3'd2, 3'd3:   n_s1.sel = rvex_pkg::SEL_MUL_HI;
                        3'd4, 3'd5:         n_s1.sel = rvex_pkg::SEL_DIV_Q;
                        default:            n_s1.sel = rvex_pkg::SEL_DIV_R;
                    endcase
                end else if (f7 == rvex_pkg::F7_ALT && (f3 == 3'd0 || f3 == 3'd5)) begin
                    n_s1.res.write_value  = rvex_pkg::alu_base(f3, 1'b1, a, b);
                    n_s1.res.write_enable = 1'b1;
                end else begin
                    n_s1.res.unknown_op = 1'b1;
                end
            end
            rvex_pkg::OPC_OPIMM: begin
                n_s1.res.write_value  = rvex_pkg::alu_base(f3, f3 == 3'd5 && imm[10], a, imm);
                n_s1.res.write_enable = 1'b1;
            end
            rvex_pkg::OPC_LOAD: begin
                case (f3)
                    3'd0:    n_s1.res.write_value = {{24{raw[7]}}, raw[7:0]};
                    3'd1:    n_s1.res.write_value = {{16{raw[15]}}, raw[15:0]};
                    3'd2:    n_s1.res.write_value = raw;
                    3'd4:    n_s1.res.write_value = {24'd0, raw[7:0]};
                    3'd5:    n_s1.res.write_value = {16'd0, raw[15:0]};
                    default: n_s1.res.unknown_op = 1'b1;
                endcase
                if (!n_s1.res.unknown_op) begin
                    n_s1.res.write_enable = 1'b1;
                    n_s1.res.mem_access   = rvex_pkg::MEM_LOAD;
                    n_s1.res.access_size  = f3[1:0];
                    n_s1.res.mem_addr     = a + imm;
                end
            end
            rvex_pkg::OPC_STORE: begin
                if (f3 <= 3'd2) begin
                    n_s1.res.mem_access  = rvex_pkg::MEM_STORE;
                    n_s1.res.access_size = f3[1:0];
                    n_s1.res.mem_addr    = a + imm;
                    case (f3[1:0])
                        rvex_pkg::SIZE_BYTE: n_s1.res.st_data = {24'd0, b[7:0]};
                        rvex_pkg::SIZE_HALF: n_s1.res.st_data = {16'd0, b[15:0]};
                        default:             n_s1.res.st_data = b;
                    endcase
                end else begin
                    n_s1.res.unknown_op = 1'b1;
                end
            end
            rvex_pkg::OPC_BRANCH: begin
                case (f3)
                    3'd0:    cond = (a == b);
                    3'd1:    cond = (a != b);
                    3'd4:    cond = $signed(a) < $signed(b);
                    3'd5:    cond = !($signed(a) < $signed(b));
                    3'd6:    cond = a < b;
                    3'd7:    cond = a >= b;
                    default: n_s1.res.unknown_op = 1'b1;
                endcase
                if (cond) begin
                    n_s1.res.branch_taken = 1'b1;
                    n_s1.res.next_addr    = pc + imm;
                end
            end
            rvex_pkg::OPC_LUI: begin
                n_s1.res.write_value  = {imm[19:0], 12'd0};
                n_s1.res.write_enable = 1'b1;
            end
            rvex_pkg::OPC_AUIPC: begin
                n_s1.res.write_value  = pc + {imm[19:0], 12'd0};
                n_s1.res.write_enable = 1'b1;
            end
            rvex_pkg::OPC_JAL: begin
                n_s1.res.write_value  = pc + 32'd4;
                n_s1.res.write_enable = 1'b1;
                n_s1.res.next_addr    = pc + imm;
            end
            rvex_pkg::OPC_JALR: begin
                n_s1.res.write_value  = pc + 32'd4;
                n_s1.res.write_enable = 1'b1;
                n_s1.res.next_addr    = (a + imm) & ~32'd1;
            end
            default: begin
                n_s1.res.unknown_op = 1'b1;
            end
        endcase
    end

    // Stage 1 registers, including the full product.
    logic              r_s1_vld;
    rvex_pkg::t_side   r_s1;
    logic [63:0]       r_prod;
    logic [31:0]       r_dividend, r_divisor;
    logic signed [65:0] n_prod;

    assign n_prod = $signed({sa & a[31], a}) * $signed({sb & b[31], b});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (en) begin
            r_s1_vld <= r_in_vld;
        end
        if (en) begin
            r_s1       <= n_s1;
            r_prod     <= n_prod[63:0];
            r_dividend <= n_dividend;
            r_divisor  <= n_divisor;
        end
    end

    // Divider and the side line that runs alongside it.
    logic [W-1:0] quot, rem;

    rvex_div u_div (
        .i_clk      (i_clk),
        .i_en       (en),
        .i_dividend (r_dividend),
        .i_divisor  (r_divisor),
        .o_quot     (quot),
        .o_rem      (rem)
    );

    logic            r_side_vld [W];
    rvex_pkg::t_side r_side     [W];
    rvex_pkg::t_side n_side0;

    always_comb begin
        n_side0 = r_s1;
        if (r_s1.sel == rvex_pkg::SEL_MUL_LO) begin
            n_side0.res.write_value = r_prod[31:0];
        end else if (r_s1.sel == rvex_pkg::SEL_MUL_HI) begin
            n_side0.res.write_value = r_prod[63:32];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < W; i++) begin
                r_side_vld[i] <= 1'b0;
            end
        end else if (en) begin
            r_side_vld[0] <= r_s1_vld;
            for (int i = 1; i < W; i++) begin
                r_side_vld[i] <= r_side_vld[i-1];
            end
        end
        if (en) begin
            r_side[0] <= n_side0;
            for (int i = 1; i < W; i++) begin
                r_side[i] <= r_side[i-1];
            end
        end
    end

    // Final stage: sign correction of the divider result and the output register.
    rvex_pkg::t_side    last;
    rvex_pkg::t_exe_out n_out;
    rvex_pkg::t_exe_out r_out;
    logic               r_out_vld;

    always_comb begin
        last  = r_side[W-1];
        n_out = last.res;
        if (last.sel == rvex_pkg::SEL_DIV_Q) begin
            if (last.div_zero) begin
                n_out.write_value = '1;
            end else begin
                n_out.write_value = last.neg_q ? 32'd0 - quot : quot;
            end
        end else if (last.sel == rvex_pkg::SEL_DIV_R) begin
            n_out.write_value = last.neg_r ? 32'd0 - rem : rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= r_side_vld[W-1];
        end
        if (en) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    // A stall freezes every valid bit of the pipeline; checked here on stage 1 and the first and last side stages.
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_s1_vld) && $stable(r_side_vld[0]) && $stable(r_side_vld[W-1]))
        else $error("pipeline valid bits moved during a stall");

    // An unknown operation never writes a register or touches memory.
    a_unknown_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.unknown_op |->
            !o_out_data.write_enable && o_out_data.mem_access == rvex_pkg::MEM_NONE
            && !o_out_data.branch_taken)
        else $error("unknown operation produced side effects");

    // An accepted transaction enters the stage after the input register.
    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready ##1 en |=> r_s1_vld)
        else $error("accepted transaction lost after the input register");
endmodule
`default_nettype wire
